// ===== rtl/lvm_pkg.sv =====
// Shared types, constants and the back-end sequence program of the look-at view matrix block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package lvm_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_UP_X    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Y    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_Z    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 8'd3;

    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;

    // one camera update after the front end: eye and saturated target - eye
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] fwd_x;
        logic signed [31:0] fwd_y;
        logic signed [31:0] fwd_z;
        logic               sat;
    } item_t;

    // operand / destination codes of the back-end register set
    typedef logic [4:0] rsel_t;
    localparam rsel_t R_EYE_X = 5'd0;
    localparam rsel_t R_EYE_Y = 5'd1;
    localparam rsel_t R_EYE_Z = 5'd2;
    localparam rsel_t R_FWD_X = 5'd3;
    localparam rsel_t R_FWD_Y = 5'd4;
    localparam rsel_t R_FWD_Z = 5'd5;
    localparam rsel_t R_UP_X  = 5'd6;
    localparam rsel_t R_UP_Y  = 5'd7;
    localparam rsel_t R_UP_Z  = 5'd8;
    localparam rsel_t R_RGT_X = 5'd9;
    localparam rsel_t R_RGT_Y = 5'd10;
    localparam rsel_t R_RGT_Z = 5'd11;
    localparam rsel_t R_TUP_X = 5'd12;
    localparam rsel_t R_TUP_Y = 5'd13;
    localparam rsel_t R_TUP_Z = 5'd14;
    localparam rsel_t R_DOT0  = 5'd15;
    localparam rsel_t R_DOT1  = 5'd16;
    localparam rsel_t R_DOT2  = 5'd17;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_NORM
    } act_t;

    // one multiply-accumulate term; act tells what happens after the last term of a sum
    typedef struct packed {
        rsel_t a;
        rsel_t b;
        logic  sub;
        act_t  act;
        logic  neg;
        rsel_t dst;
    } uop_t;

    localparam int PC_W     = 5;
    localparam int PROG_LEN = 27;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_ACC,
        B_SQRT,
        B_NCHK,
        B_DLOAD,
        B_DIV,
        B_DWR,
        B_OUT
    } bstate_t;

    function automatic uop_t mk(input rsel_t a, input rsel_t b, input logic sub,
                                input act_t act, input logic neg, input rsel_t dst);
        uop_t u;
        u.a   = a;
        u.b   = b;
        u.sub = sub;
        u.act = act;
        u.neg = neg;
        u.dst = dst;
        return u;
    endfunction

    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // |fwd|^2, then normalize fwd
            5'd0:  u = mk(R_FWD_X, R_FWD_X, 1'b0, ACT_NONE,  1'b0, R_FWD_X);
            5'd1:  u = mk(R_FWD_Y, R_FWD_Y, 1'b0, ACT_NONE,  1'b0, R_FWD_X);
            5'd2:  u = mk(R_FWD_Z, R_FWD_Z, 1'b0, ACT_NORM,  1'b0, R_FWD_X);
            // rgt = fwd x up
            5'd3:  u = mk(R_FWD_Y, R_UP_Z,  1'b0, ACT_NONE,  1'b0, R_RGT_X);
            5'd4:  u = mk(R_FWD_Z, R_UP_Y,  1'b1, ACT_WRITE, 1'b0, R_RGT_X);
            5'd5:  u = mk(R_FWD_Z, R_UP_X,  1'b0, ACT_NONE,  1'b0, R_RGT_Y);
            5'd6:  u = mk(R_FWD_X, R_UP_Z,  1'b1, ACT_WRITE, 1'b0, R_RGT_Y);
            5'd7:  u = mk(R_FWD_X, R_UP_Y,  1'b0, ACT_NONE,  1'b0, R_RGT_Z);
            5'd8:  u = mk(R_FWD_Y, R_UP_X,  1'b1, ACT_WRITE, 1'b0, R_RGT_Z);
            // |rgt|^2, then normalize rgt
            5'd9:  u = mk(R_RGT_X, R_RGT_X, 1'b0, ACT_NONE,  1'b0, R_RGT_X);
            5'd10: u = mk(R_RGT_Y, R_RGT_Y, 1'b0, ACT_NONE,  1'b0, R_RGT_X);
            5'd11: u = mk(R_RGT_Z, R_RGT_Z, 1'b0, ACT_NORM,  1'b0, R_RGT_X);
            // tup = rgt x fwd
            5'd12: u = mk(R_RGT_Y, R_FWD_Z, 1'b0, ACT_NONE,  1'b0, R_TUP_X);
            5'd13: u = mk(R_RGT_Z, R_FWD_Y, 1'b1, ACT_WRITE, 1'b0, R_TUP_X);
            5'd14: u = mk(R_RGT_Z, R_FWD_X, 1'b0, ACT_NONE,  1'b0, R_TUP_Y);
            5'd15: u = mk(R_RGT_X, R_FWD_Z, 1'b1, ACT_WRITE, 1'b0, R_TUP_Y);
            5'd16: u = mk(R_RGT_X, R_FWD_Y, 1'b0, ACT_NONE,  1'b0, R_TUP_Z);
            5'd17: u = mk(R_RGT_Y, R_FWD_X, 1'b1, ACT_WRITE, 1'b0, R_TUP_Z);
            // translation column
            5'd18: u = mk(R_RGT_X, R_EYE_X, 1'b0, ACT_NONE,  1'b0, R_DOT0);
            5'd19: u = mk(R_RGT_Y, R_EYE_Y, 1'b0, ACT_NONE,  1'b0, R_DOT0);
            5'd20: u = mk(R_RGT_Z, R_EYE_Z, 1'b0, ACT_WRITE, 1'b1, R_DOT0);
            5'd21: u = mk(R_TUP_X, R_EYE_X, 1'b0, ACT_NONE,  1'b0, R_DOT1);
            5'd22: u = mk(R_TUP_Y, R_EYE_Y, 1'b0, ACT_NONE,  1'b0, R_DOT1);
            5'd23: u = mk(R_TUP_Z, R_EYE_Z, 1'b0, ACT_WRITE, 1'b1, R_DOT1);
            5'd24: u = mk(R_FWD_X, R_EYE_X, 1'b0, ACT_NONE,  1'b0, R_DOT2);
            5'd25: u = mk(R_FWD_Y, R_EYE_Y, 1'b0, ACT_NONE,  1'b0, R_DOT2);
            5'd26: u = mk(R_FWD_Z, R_EYE_Z, 1'b0, ACT_WRITE, 1'b0, R_DOT2);
            default: u = mk(R_EYE_X, R_EYE_X, 1'b0, ACT_NONE, 1'b0, R_EYE_X);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lvm_if.sv =====
// Valid/ready channel interfaces of the look-at view matrix block: input, result, config write.
// Depends on lvm_pkg for the config index width.
`timescale 1ns / 1ps
`default_nettype none

interface lvm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;

    modport source(output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                   input ready);
    modport sink(input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                 output ready);
endinterface

interface lvm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         group_index;
    logic signed [31:0] entry_a;
    logic signed [31:0] entry_b;
    logic signed [31:0] entry_c;
    logic signed [31:0] entry_d;
    logic               forward_short;
    logic               right_short;
    logic               saturated;
    logic               last;

    modport source(output valid, group_index, entry_a, entry_b, entry_c, entry_d,
                   forward_short, right_short, saturated, last, input ready);
    modport sink(input valid, group_index, entry_a, entry_b, entry_c, entry_d,
                 forward_short, right_short, saturated, last, output ready);
endinterface

interface lvm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lvm_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lookat_view_matrix_core.sv =====
// Top level of the right-handed look-at view matrix block: config registers,
// front end, item queue and back end. Depends on lvm_pkg, lvm_if, lvm_front, lvm_fifo, lvm_back.
//
//  channel  | dir | payload                                         | transaction
//  ---------+-----+-------------------------------------------------+------------------------
//  in_ch    | in  | eye_x/y/z, target_x/y/z                         | one camera update
//  out_ch   | out | group_index, entry_a..d, flags, last            | four entries, 4 per update
//  cfg_ch   | in  | index, data                                     | one register write
//
// Values are Q16.16 by default. Each update in the back end is paced by the shared 32x32
// multiplier (27 terms), the bitwise square root and up to six divisions with FRAC_BITS+1
// quotient bits each. The front end takes a transaction per cycle while the queue has
// room. Reset clears control state only; config resets to up=(0,1,0), min_length=1.
// Either side may stall; the result register holds until taken.
`timescale 1ns / 1ps
`default_nettype none

module lookat_view_matrix_core #(
    parameter int FRAC_BITS   = lvm_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = lvm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lvm_in_if.sink      in_ch,
    lvm_out_if.source   out_ch,
    lvm_cfg_if.sink     cfg_ch
);

    logic signed [31:0] up_x_reg;
    logic signed [31:0] up_y_reg;
    logic signed [31:0] up_z_reg;
    logic [15:0]        min_len_reg;

    lvm_pkg::item_t push_item;
    logic           push_valid;
    logic           push_ready;
    lvm_pkg::item_t pop_item;
    logic           pop_valid;
    logic           pop_ready;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg    <= 32'sd0;
            up_y_reg    <= 32'sd1 <<< FRAC_BITS;
            up_z_reg    <= 32'sd0;
            min_len_reg <= 16'd1;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                lvm_pkg::REG_UP_X:    up_x_reg    <= cfg_ch.data;
                lvm_pkg::REG_UP_Y:    up_y_reg    <= cfg_ch.data;
                lvm_pkg::REG_UP_Z:    up_z_reg    <= cfg_ch.data;
                lvm_pkg::REG_MIN_LEN: min_len_reg <= cfg_ch.data[15:0];
                default:              ;
            endcase
        end
    end

    lvm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    lvm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    lvm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .up_x       (up_x_reg),
        .up_y       (up_y_reg),
        .up_z       (up_z_reg),
        .min_length (min_len_reg),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== rtl/lvm_front.sv =====
// Front end: accepts input transactions, forms the saturated forward difference.
// Depends on lvm_pkg (item_t) and lvm_if (input channel).
`timescale 1ns / 1ps
`default_nettype none

module lvm_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lvm_in_if.sink              in_ch,
    output lvm_pkg::item_t      push_item,
    output logic                push_valid,
    input  wire logic           push_ready
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    lvm_pkg::item_t hold_reg;
    lvm_pkg::item_t hold_next;
    logic           accept;

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] t,
                                                    input logic signed [31:0] e,
                                                    output logic clamped);
        logic signed [32:0] d;
        d = 33'(t) - 33'(e);
        clamped = (d[32] != d[31]);
        if (!clamped)
            return d[31:0];
        else if (d[32])
            return lvm_pkg::MIN32;
        else
            return lvm_pkg::MAX32;
    endfunction

    assign in_ch.ready = !hold_valid_reg || push_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push_valid  = hold_valid_reg;
    assign push_item   = hold_reg;

    always_comb
    begin
        logic cx;
        logic cy;
        logic cz;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg && !push_ready;
        cx = 1'b0;
        cy = 1'b0;
        cz = 1'b0;
        if (accept)
        begin
            hold_next.eye_x = in_ch.eye_x;
            hold_next.eye_y = in_ch.eye_y;
            hold_next.eye_z = in_ch.eye_z;
            hold_next.fwd_x = sat_diff(in_ch.target_x, in_ch.eye_x, cx);
            hold_next.fwd_y = sat_diff(in_ch.target_y, in_ch.eye_y, cy);
            hold_next.fwd_z = sat_diff(in_ch.target_z, in_ch.eye_z, cz);
            hold_next.sat   = cx || cy || cz;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lvm_fifo.sv =====
// Short queue of front-end items between the front end and the back end.
// Depends on lvm_pkg (item_t).
`timescale 1ns / 1ps
`default_nettype none

module lvm_fifo #(
    parameter int DEPTH = lvm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  lvm_pkg::item_t      push_item,
    input  wire logic           push_valid,
    output logic                push_ready,
    output lvm_pkg::item_t      pop_item,
    output logic                pop_valid,
    input  wire logic           pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lvm_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== rtl/lvm_back.sv =====
// Back end: sequencer over one shared multiplier, a bitwise square root and a
// restoring divider; builds the matrix and drives the result register.
// Depends on lvm_pkg (program, types) and lvm_if (result channel).
`timescale 1ns / 1ps
`default_nettype none

module lvm_back #(
    parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  lvm_pkg::item_t          pop_item,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire logic signed [31:0] up_x,
    input  wire logic signed [31:0] up_y,
    input  wire logic signed [31:0] up_z,
    input  wire logic [15:0]        min_length,
    lvm_out_if.source               out_ch
);

    localparam int DW = 32 + FRAC_BITS;
    localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAX_W    = 66'sd2147483647;
    localparam logic signed [65:0] MIN_W    = -66'sd2147483648;
    localparam logic signed [31:0] FX_ONE   = 32'sd1 <<< FRAC_BITS;

    lvm_pkg::bstate_t state_reg, state_next;
    logic [lvm_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [5:0]               cnt_reg, cnt_next;
    logic [1:0]               comp_reg, comp_next;
    logic [1:0]               group_reg, group_next;
    logic signed [65:0]       acc_reg, acc_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic [63:0]              sq_reg, sq_next;
    logic [35:0]              srem_reg, srem_next;
    logic [31:0]              root_reg, root_next;
    logic [31:0]              drem_reg, drem_next;
    logic [FRAC_BITS:0]       dnum_reg, dnum_next;
    logic [FRAC_BITS:0]       quo_reg, quo_next;
    logic                     dneg_reg, dneg_next;
    logic                     fshort_reg, fshort_next;
    logic                     rshort_reg, rshort_next;
    logic                     sat_reg, sat_next;

    logic signed [31:0] ex_reg, ey_reg, ez_reg;
    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic signed [31:0] d0_reg, d1_reg, d2_reg;

    logic                     ovalid_reg, ovalid_next;
    logic [1:0]               ogrp_reg, ogrp_next;
    logic signed [31:0]       oa_reg, oa_next;
    logic signed [31:0]       ob_reg, ob_next;
    logic signed [31:0]       oc_reg, oc_next;
    logic signed [31:0]       od_reg, od_next;
    logic                     ofs_reg, ofs_next;
    logic                     ors_reg, ors_next;
    logic                     osat_reg, osat_next;

    lvm_pkg::uop_t      uop;
    lvm_pkg::rsel_t     csel;
    lvm_pkg::rsel_t     wr_idx;
    logic               wr_en;
    logic signed [31:0] wr_val;
    logic               load;

    function automatic logic signed [31:0] rd(input lvm_pkg::rsel_t s);
        case (s)
            lvm_pkg::R_EYE_X: return ex_reg;
            lvm_pkg::R_EYE_Y: return ey_reg;
            lvm_pkg::R_EYE_Z: return ez_reg;
            lvm_pkg::R_FWD_X: return fx_reg;
            lvm_pkg::R_FWD_Y: return fy_reg;
            lvm_pkg::R_FWD_Z: return fz_reg;
            lvm_pkg::R_UP_X:  return up_x;
            lvm_pkg::R_UP_Y:  return up_y;
            lvm_pkg::R_UP_Z:  return up_z;
            lvm_pkg::R_RGT_X: return rx_reg;
            lvm_pkg::R_RGT_Y: return ry_reg;
            lvm_pkg::R_RGT_Z: return rz_reg;
            lvm_pkg::R_TUP_X: return tx_reg;
            lvm_pkg::R_TUP_Y: return ty_reg;
            lvm_pkg::R_TUP_Z: return tz_reg;
            lvm_pkg::R_DOT0:  return d0_reg;
            lvm_pkg::R_DOT1:  return d1_reg;
            lvm_pkg::R_DOT2:  return d2_reg;
            default:          return '0;
        endcase
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        if (v == lvm_pkg::MIN32)
            return lvm_pkg::MAX32;
        else
            return -v;
    endfunction

    assign uop  = lvm_pkg::prog(pc_reg);
    assign csel = uop.dst + lvm_pkg::rsel_t'(comp_reg);

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.group_index   = ogrp_reg;
    assign out_ch.entry_a       = oa_reg;
    assign out_ch.entry_b       = ob_reg;
    assign out_ch.entry_c       = oc_reg;
    assign out_ch.entry_d       = od_reg;
    assign out_ch.forward_short = ofs_reg;
    assign out_ch.right_short   = ors_reg;
    assign out_ch.saturated     = osat_reg;
    assign out_ch.last          = (ogrp_reg == 2'd3);

    always_comb
    begin
        logic signed [65:0] sum;
        logic signed [65:0] rnd;
        logic signed [31:0] cval;
        logic [32:0]        mag;
        logic [DW-1:0]      nval;
        logic [35:0]        rem_t;
        logic [35:0]        trial;
        logic [32:0]        dt;
        logic               slot_free;

        state_next  = state_reg;
        pc_next     = pc_reg;
        cnt_next    = cnt_reg;
        comp_next   = comp_reg;
        group_next  = group_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        sq_next     = sq_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        drem_next   = drem_reg;
        dnum_next   = dnum_reg;
        quo_next    = quo_reg;
        dneg_next   = dneg_reg;
        fshort_next = fshort_reg;
        rshort_next = rshort_reg;
        sat_next    = sat_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        ogrp_next   = ogrp_reg;
        oa_next     = oa_reg;
        ob_next     = ob_reg;
        oc_next     = oc_reg;
        od_next     = od_reg;
        ofs_next    = ofs_reg;
        ors_next    = ors_reg;
        osat_next   = osat_reg;
        wr_en       = 1'b0;
        wr_idx      = uop.dst;
        wr_val      = '0;
        load        = 1'b0;
        pop_ready   = 1'b0;
        slot_free   = !ovalid_reg || out_ch.ready;

        sum   = acc_reg + (uop.sub ? -66'(prod_reg) : 66'(prod_reg));
        rnd   = (sum + RND_HALF) >>> FRAC_BITS;
        if (uop.neg)
            rnd = -rnd;
        cval  = rd(csel);
        mag   = cval[31] ? (33'd0 - 33'(cval)) : 33'(cval);
        nval  = {mag[31:0], {FRAC_BITS{1'b0}}} + DW'(root_reg >> 1);
        rem_t = {srem_reg[33:0], sq_reg[63:62]};
        trial = {2'b00, root_reg, 2'b01};
        dt    = {drem_reg, dnum_reg[FRAC_BITS]};

        case (state_reg)
            lvm_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    load        = 1'b1;
                    sat_next    = pop_item.sat;
                    fshort_next = 1'b0;
                    rshort_next = 1'b0;
                    acc_next    = '0;
                    pc_next     = '0;
                    state_next  = lvm_pkg::B_MUL;
                end
            end
            lvm_pkg::B_MUL:
            begin
                prod_next  = rd(uop.a) * rd(uop.b);
                state_next = lvm_pkg::B_ACC;
            end
            lvm_pkg::B_ACC:
            begin
                case (uop.act)
                    lvm_pkg::ACT_WRITE:
                    begin
                        wr_en    = 1'b1;
                        acc_next = '0;
                        if (rnd > MAX_W)
                        begin
                            wr_val   = lvm_pkg::MAX32;
                            sat_next = 1'b1;
                        end
                        else if (rnd < MIN_W)
                        begin
                            wr_val   = lvm_pkg::MIN32;
                            sat_next = 1'b1;
                        end
                        else
                            wr_val = rnd[31:0];
                        if (pc_reg == lvm_pkg::PC_W'(lvm_pkg::PROG_LEN - 1))
                        begin
                            group_next = '0;
                            state_next = lvm_pkg::B_OUT;
                        end
                        else
                        begin
                            pc_next    = pc_reg + lvm_pkg::PC_W'(1);
                            state_next = lvm_pkg::B_MUL;
                        end
                    end
                    lvm_pkg::ACT_NORM:
                    begin
                        acc_next   = '0;
                        sq_next    = sum[63:0];
                        srem_next  = '0;
                        root_next  = '0;
                        cnt_next   = '0;
                        state_next = lvm_pkg::B_SQRT;
                    end
                    default:
                    begin
                        acc_next   = sum;
                        pc_next    = pc_reg + lvm_pkg::PC_W'(1);
                        state_next = lvm_pkg::B_MUL;
                    end
                endcase
            end
            lvm_pkg::B_SQRT:
            begin
                // two radicand bits per cycle, one root bit
                if (rem_t >= trial)
                begin
                    srem_next = rem_t - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_next = rem_t;
                    root_next = {root_reg[30:0], 1'b0};
                end
                sq_next  = {sq_reg[61:0], 2'b00};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = lvm_pkg::B_NCHK;
            end
            lvm_pkg::B_NCHK:
            begin
                if (root_reg <= 32'(min_length))
                begin
                    if (uop.dst == lvm_pkg::R_FWD_X)
                        fshort_next = 1'b1;
                    else
                        rshort_next = 1'b1;
                    pc_next    = pc_reg + lvm_pkg::PC_W'(1);
                    state_next = lvm_pkg::B_MUL;
                end
                else
                begin
                    comp_next  = '0;
                    state_next = lvm_pkg::B_DLOAD;
                end
            end
            lvm_pkg::B_DLOAD:
            begin
                // quotient stays below 2^(F+1), so the high part starts as the remainder
                dneg_next  = cval[31];
                drem_next  = {1'b0, nval[DW-1:FRAC_BITS+1]};
                dnum_next  = nval[FRAC_BITS:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = lvm_pkg::B_DIV;
            end
            lvm_pkg::B_DIV:
            begin
                if (dt >= {1'b0, root_reg})
                begin
                    drem_next = 32'(dt - {1'b0, root_reg});
                    quo_next  = {quo_reg[FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    drem_next = dt[31:0];
                    quo_next  = {quo_reg[FRAC_BITS-1:0], 1'b0};
                end
                dnum_next = {dnum_reg[FRAC_BITS-1:0], 1'b0};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(FRAC_BITS))
                    state_next = lvm_pkg::B_DWR;
            end
            lvm_pkg::B_DWR:
            begin
                wr_en  = 1'b1;
                wr_idx = csel;
                wr_val = dneg_reg ? -(32'(quo_reg)) : 32'(quo_reg);
                if (comp_reg == 2'd2)
                begin
                    pc_next    = pc_reg + lvm_pkg::PC_W'(1);
                    state_next = lvm_pkg::B_MUL;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = lvm_pkg::B_DLOAD;
                end
            end
            lvm_pkg::B_OUT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ogrp_next   = group_reg;
                    ofs_next    = fshort_reg;
                    ors_next    = rshort_reg;
                    osat_next   = sat_reg || (fx_reg == lvm_pkg::MIN32)
                                  || (fy_reg == lvm_pkg::MIN32)
                                  || (fz_reg == lvm_pkg::MIN32);
                    case (group_reg)
                        2'd0:
                        begin
                            oa_next = rx_reg;
                            ob_next = tx_reg;
                            oc_next = neg_sat(fx_reg);
                            od_next = '0;
                        end
                        2'd1:
                        begin
                            oa_next = ry_reg;
                            ob_next = ty_reg;
                            oc_next = neg_sat(fy_reg);
                            od_next = '0;
                        end
                        2'd2:
                        begin
                            oa_next = rz_reg;
                            ob_next = tz_reg;
                            oc_next = neg_sat(fz_reg);
                            od_next = '0;
                        end
                        default:
                        begin
                            oa_next = d0_reg;
                            ob_next = d1_reg;
                            oc_next = d2_reg;
                            od_next = FX_ONE;
                        end
                    endcase
                    group_next = group_reg + 2'd1;
                    if (group_reg == 2'd3)
                        state_next = lvm_pkg::B_IDLE;
                end
            end
            default:
                state_next = lvm_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lvm_pkg::B_IDLE;
            pc_reg     <= '0;
            cnt_reg    <= '0;
            comp_reg   <= '0;
            group_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            cnt_reg    <= cnt_next;
            comp_reg   <= comp_next;
            group_reg  <= group_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        sq_reg     <= sq_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        dnum_reg   <= dnum_next;
        quo_reg    <= quo_next;
        dneg_reg   <= dneg_next;
        fshort_reg <= fshort_next;
        rshort_reg <= rshort_next;
        sat_reg    <= sat_next;
        ogrp_reg   <= ogrp_next;
        oa_reg     <= oa_next;
        ob_reg     <= ob_next;
        oc_reg     <= oc_next;
        od_reg     <= od_next;
        ofs_reg    <= ofs_next;
        ors_reg    <= ors_next;
        osat_reg   <= osat_next;
        if (load)
        begin
            ex_reg <= pop_item.eye_x;
            ey_reg <= pop_item.eye_y;
            ez_reg <= pop_item.eye_z;
            fx_reg <= pop_item.fwd_x;
            fy_reg <= pop_item.fwd_y;
            fz_reg <= pop_item.fwd_z;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                lvm_pkg::R_FWD_X: fx_reg <= wr_val;
                lvm_pkg::R_FWD_Y: fy_reg <= wr_val;
                lvm_pkg::R_FWD_Z: fz_reg <= wr_val;
                lvm_pkg::R_RGT_X: rx_reg <= wr_val;
                lvm_pkg::R_RGT_Y: ry_reg <= wr_val;
                lvm_pkg::R_RGT_Z: rz_reg <= wr_val;
                lvm_pkg::R_TUP_X: tx_reg <= wr_val;
                lvm_pkg::R_TUP_Y: ty_reg <= wr_val;
                lvm_pkg::R_TUP_Z: tz_reg <= wr_val;
                lvm_pkg::R_DOT0:  d0_reg <= wr_val;
                lvm_pkg::R_DOT1:  d1_reg <= wr_val;
                lvm_pkg::R_DOT2:  d2_reg <= wr_val;
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire
